// ----- rtl/per_channel_median_filter_unit_assert.svh -----
// Assertion macros used by the median filter back end.
`ifndef PER_CHANNEL_MEDIAN_FILTER_UNIT_ASSERT_SVH
`define PER_CHANNEL_MEDIAN_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define PCMF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent in the following cycle.
`define PCMF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);
// Condition must never hold.
`define PCMF_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) !(cond)) \
    else $error(msg);
`else
`define PCMF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define PCMF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`define PCMF_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg)
`endif
`endif

// ----- rtl/pcmf_pkg.sv -----
// Types and constants shared by the median filter modules.
package pcmf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CH_W     = 3;
  localparam int CMD_W    = 16;

  // Converter command words per channel.
  localparam logic [CMD_W-1:0] CMD_CH0 = 16'h8400;
  localparam logic [CMD_W-1:0] CMD_CH1 = 16'hC400;

  // Classified word handed from the front end to the back end.
  typedef struct packed {
    logic                acc;
    logic                ch;
    logic [SAMPLE_W-1:0] sample;
    logic [CMD_W-1:0]    cmd;
  } pcmf_entry_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } pcmf_qstat_t;

  // One result word.
  typedef struct packed {
    logic                acc;
    logic [SAMPLE_W-1:0] median;
    logic [SAMPLE_W-1:0] prev;
    logic [CMD_W-1:0]    cmd;
  } pcmf_result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RANK,
    BK_EMIT
  } pcmf_bstate_t;

endpackage

// ----- rtl/pcmf_front.sv -----
// Front end: accepts input words, checks the channel and picks the command word.
module pcmf_front import pcmf_pkg::*; #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [CH_W-1:0]     in_channel,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  pcmf_qstat_t         qstat,
  output logic                push,
  output pcmf_entry_t         push_entry
);

  logic chan_ok;

  // Only channels that exist and that the converter knows are taken.
  assign chan_ok = (in_channel < CH_W'(NUM_CHANNELS)) && (in_channel <= CH_W'(1));

  always_comb begin
    push_entry.acc    = chan_ok;
    push_entry.ch     = in_channel[0];
    push_entry.sample = in_sample;
    if (!chan_ok) begin
      push_entry.cmd = '0;
    end else if (in_channel[0]) begin
      push_entry.cmd = CMD_CH1;
    end else begin
      push_entry.cmd = CMD_CH0;
    end
  end

  // The front end stalls only when the queue is full.
  assign in_tready = !qstat.full;
  assign push      = in_tvalid && !qstat.full;

endmodule

// ----- rtl/pcmf_queue.sv -----
// Two-entry queue between the front end and the back end.
module pcmf_queue import pcmf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  pcmf_entry_t push_entry,
  input  logic        pop,
  output pcmf_entry_t head,
  output pcmf_qstat_t qstat
);

  localparam int DEPTH = 2;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pcmf_entry_t      mem_r [DEPTH];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign head        = mem_r[rd_ptr_r];
  assign qstat.full  = (cnt_r == CNT_W'(DEPTH));
  assign qstat.empty = (cnt_r == '0);

endmodule

// ----- rtl/pcmf_back.sv -----
// Back end: updates the channel window, ranks it one candidate per cycle and emits the result.
`include "per_channel_median_filter_unit_assert.svh"
module pcmf_back import pcmf_pkg::*; #(
  parameter int WINDOW_SIZE  = 5,
  parameter int NUM_CHANNELS = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  pcmf_qstat_t  qstat,
  input  pcmf_entry_t  head,
  output logic         pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output pcmf_result_t result
);

  localparam int POS_W  = $clog2(WINDOW_SIZE);
  localparam int RANK_W = $clog2(WINDOW_SIZE + 1);
  localparam int MID    = WINDOW_SIZE / 2;

  // Architectural state per channel.
  logic signed [SAMPLE_W-1:0] store_r   [NUM_CHANNELS][WINDOW_SIZE];
  logic        [POS_W-1:0]    pos_r     [NUM_CHANNELS];
  logic signed [SAMPLE_W-1:0] cur_med_r [NUM_CHANNELS];

  // Working state of the word in progress.
  pcmf_bstate_t               state_r, state_nxt;
  logic        [POS_W-1:0]    idx_r, idx_nxt;
  logic                       acc_r;
  logic                       ch_r;
  logic        [CMD_W-1:0]    cmd_r;
  logic signed [SAMPLE_W-1:0] wk_r  [WINDOW_SIZE];
  logic signed [SAMPLE_W-1:0] rot_r [WINDOW_SIZE];
  logic signed [SAMPLE_W-1:0] med_r;
  logic                       found_r;
  logic                       out_valid_r;
  pcmf_result_t               res_r;

  logic                       take;
  logic                       rank_en;
  logic                       emit;
  logic                       out_free;
  logic signed [SAMPLE_W-1:0] row_sel [WINDOW_SIZE];
  logic signed [SAMPLE_W-1:0] row_new [WINDOW_SIZE];
  logic        [POS_W-1:0]    pos_sel;
  logic        [POS_W-1:0]    pos_new;
  logic signed [SAMPLE_W-1:0] prev_sel;
  logic        [WINDOW_SIZE-1:0] lt;
  logic        [RANK_W-1:0]   rank;
  logic                       is_mid;

  assign out_free = !out_valid_r || out_tready;

  // Window and position of the channel at the queue head.
  always_comb begin
    row_sel = store_r[0];
    pos_sel = pos_r[0];
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (head.ch == 1'(c)) begin
        row_sel = store_r[c];
        pos_sel = pos_r[c];
      end
    end
  end

  // The position advances with wrap before the sample is stored.
  assign pos_new = (pos_sel >= POS_W'(WINDOW_SIZE - 1)) ? '0 : pos_sel + 1'b1;

  always_comb begin
    for (int k = 0; k < WINDOW_SIZE; k++) begin
      row_new[k] = (POS_W'(k) == pos_new) ? $signed(head.sample) : row_sel[k];
    end
  end

  // Median the channel gave before this sample.
  always_comb begin
    prev_sel = cur_med_r[0];
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (ch_r == 1'(c)) begin
        prev_sel = cur_med_r[c];
      end
    end
  end

  // Stable rank of the current candidate: smaller entries, plus equal ones
  // that sit at a lower slot.
  always_comb begin
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      lt[j] = (wk_r[j] < rot_r[0]) || ((wk_r[j] == rot_r[0]) && (POS_W'(j) < idx_r));
    end
  end

  assign rank   = RANK_W'($countones(lt));
  assign is_mid = (rank == RANK_W'(MID));

  // Sequencer: take a word, rank each slot in turn, then emit.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    take      = 1'b0;
    rank_en   = 1'b0;
    emit      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!qstat.empty) begin
          pop       = 1'b1;
          take      = 1'b1;
          idx_nxt   = '0;
          state_nxt = head.acc ? BK_RANK : BK_EMIT;
        end
      end
      BK_RANK: begin
        rank_en = 1'b1;
        if (idx_r == POS_W'(WINDOW_SIZE - 1)) begin
          state_nxt = BK_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Channel windows, positions and medians, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        pos_r[c]     <= '0;
        cur_med_r[c] <= '0;
        for (int k = 0; k < WINDOW_SIZE; k++) begin
          store_r[c][k] <= '0;
        end
      end
    end else begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (take && head.acc && (head.ch == 1'(c))) begin
          store_r[c] <= row_new;
          pos_r[c]   <= pos_new;
        end
        if (emit && acc_r && (ch_r == 1'(c))) begin
          cur_med_r[c] <= med_r;
        end
      end
    end
  end

  // Working copies: wk_r stays fixed, rot_r turns so slot zero is the candidate.
  always_ff @(posedge clk) begin
    if (take) begin
      acc_r <= head.acc;
      ch_r  <= head.ch;
      cmd_r <= head.cmd;
      wk_r  <= row_new;
      rot_r <= row_new;
    end else if (rank_en) begin
      for (int k = 0; k < WINDOW_SIZE; k++) begin
        rot_r[k] <= rot_r[(k + 1) % WINDOW_SIZE];
      end
      if (is_mid) begin
        med_r <= rot_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b0;
    end else if (rank_en && is_mid) begin
      found_r <= 1'b1;
    end
  end

  // Output register decouples the back end from the receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (acc_r) begin
        res_r.acc    <= 1'b1;
        res_r.median <= med_r;
        res_r.prev   <= prev_sel;
        res_r.cmd    <= cmd_r;
      end else begin
        res_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign result     = res_r;

  `PCMF_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, !qstat.empty, "pop from empty queue")
  `PCMF_ASSERT_IMP(a_rank_valid_only, clk, rst_n, state_r == BK_RANK, acc_r, "ranking a rejected word")
  `PCMF_ASSERT_NEXT(a_median_found, clk, rst_n, (state_r == BK_RANK) && (idx_r == POS_W'(WINDOW_SIZE - 1)), found_r, "no slot had the middle rank")

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_pos_chk
    `PCMF_ASSERT_NEVER(a_pos_range, clk, rst_n, pos_r[g] > POS_W'(WINDOW_SIZE - 1), "write position out of range")
  end

endmodule

// ----- rtl/per_channel_median_filter_unit.sv -----
// Top level of the per-channel sliding-window median filter.
//
// Input channel: in_tdata carries a signed 16-bit converter sample and in_tuser the
// channel number. Channels 0 and 1 (below NUM_CHANNELS) are stored; any other
// channel leaves all state alone and yields a word with accepted clear and zeros.
// Result channel: one word per input word, in order, with the median of that
// channel's window after the store, the median it gave before, and its converter
// command word (0x8400 for channel 0, 0xC400 for channel 1).
// The rank unit tests one window slot per cycle against all others; the back end
// takes the next word from the queue only after the current one is emitted.
// A two-entry queue lets the input side take words while the back end works, and
// the output register holds a finished word while the next one is ranked.
// Reset: windows, write positions and stored medians are cleared to zero; the queue
// and output are emptied. No clearing pass is needed.
// A stalled receiver holds the output word; the back end then waits, the queue
// fills and in_tready falls.
module per_channel_median_filter_unit import pcmf_pkg::*; #(
  parameter int WINDOW_SIZE  = 5,
  parameter int NUM_CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic [2:0]  in_tuser,   // [2:0] channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] median, [31:16] previous_median, [47:32] command_word
  output logic [0:0]  out_tuser   // [0] accepted
);

  pcmf_qstat_t  qstat;
  pcmf_entry_t  push_entry;
  pcmf_entry_t  head;
  pcmf_result_t result;
  logic         push;
  logic         pop;

  pcmf_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_channel (in_tuser),
    .in_sample  (in_tdata),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  pcmf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  pcmf_back #(
    .WINDOW_SIZE  (WINDOW_SIZE),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .result     (result)
  );

  assign out_tdata = {result.cmd, result.prev, result.median};
  assign out_tuser = result.acc;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the per-channel sliding-window median filter.
`timescale 1ns / 1ps

module testbench;
  import pcmf_pkg::*;

  localparam int WINDOW_SIZE  = 5;
  localparam int NUM_CHANNELS = 2;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_PER_PHASE = 500;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4 * (WINDOW_SIZE + 2);
  localparam logic [15:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [15:0] SAMPLE_MIN = 16'h8000;
  localparam logic [15:0] SAMPLE_NEG1 = 16'hFFFF;

  // One row of the directed table; typed rows carry a hand-written expectation.
  typedef struct {
    logic [2:0]  ch;
    logic [15:0] smp;
    bit          typed;
    logic        exp_acc;
    logic [15:0] exp_med;
    logic [15:0] exp_prev;
    logic [15:0] exp_cmd;
  } stim_row_t;

  localparam int DIRECTED_N = 23;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] sample
  logic [2:0]  in_tuser;   // [2:0] channel
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [15:0] median, [31:16] previous_median, [47:32] command_word
  logic [0:0]  out_tuser;  // [0] accepted

  // Shadow copy of the filter state.
  logic signed [15:0] win_mem [NUM_CHANNELS][WINDOW_SIZE];
  int unsigned        wr_slot [NUM_CHANNELS];
  logic signed [15:0] med_now [NUM_CHANNELS];
  logic signed [15:0] med_before [NUM_CHANNELS];

  pcmf_result_t pending_results[$];
  int           fail_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_requests;
  int           hold_served;

  stim_row_t directed_rows [DIRECTED_N] = '{
    '{3'd0, SAMPLE_MAX, 1'b1, 1'b1, 16'h0000, 16'h0000, CMD_CH0},
    '{3'd1, SAMPLE_MIN, 1'b1, 1'b1, 16'h0000, 16'h0000, CMD_CH1},
    '{3'd2, 16'h1234,   1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd3, SAMPLE_NEG1, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd4, 16'h0000,   1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd5, SAMPLE_MIN, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd6, SAMPLE_MAX, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd7, 16'h5A5A,   1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd0, SAMPLE_MAX, 1'b1, 1'b1, 16'h0000, 16'h0000, CMD_CH0},
    '{3'd0, SAMPLE_MAX, 1'b1, 1'b1, SAMPLE_MAX, 16'h0000, CMD_CH0},
    '{3'd0, SAMPLE_MAX, 1'b1, 1'b1, SAMPLE_MAX, SAMPLE_MAX, CMD_CH0},
    // The next channel 0 word wraps the write position back to slot 0.
    '{3'd0, SAMPLE_MIN, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd0, SAMPLE_MIN, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd0, SAMPLE_MIN, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd1, SAMPLE_MIN, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd1, SAMPLE_MIN, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd1, 16'h0001,   1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd1, SAMPLE_NEG1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd1, 16'h0000,   1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd2, 16'h0000,   1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd0, 16'h0000,   1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd0, SAMPLE_NEG1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
    '{3'd0, 16'h0001,   1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000}
  };

  per_channel_median_filter_unit #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Safety net in case the handshakes never complete.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Sorts a copy of one channel window and picks the middle slot.
  function automatic logic signed [15:0] window_median(input int unsigned c);
    logic signed [15:0] sorted [WINDOW_SIZE];
    logic signed [15:0] tmp;
    for (int i = 0; i < WINDOW_SIZE; i++) sorted[i] = win_mem[c][i];
    for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
      for (int j = 0; j < WINDOW_SIZE - 1 - i; j++) begin
        if (sorted[j] > sorted[j+1]) begin
          tmp = sorted[j];
          sorted[j] = sorted[j+1];
          sorted[j+1] = tmp;
        end
      end
    end
    return sorted[WINDOW_SIZE/2];
  endfunction

  // Updates the shadow state for one accepted word and returns the expected result.
  function automatic pcmf_result_t filter_predict(input logic [2:0] ch, input logic [15:0] smp);
    pcmf_result_t res;
    int unsigned  c;
    res = '0;
    if (ch < NUM_CHANNELS && ch <= 1) begin
      c = ch;
      wr_slot[c] = (wr_slot[c] >= WINDOW_SIZE - 1) ? 0 : wr_slot[c] + 1;
      win_mem[c][wr_slot[c]] = smp;
      med_before[c] = med_now[c];
      med_now[c] = window_median(c);
      res.acc = 1'b1;
      res.median = med_now[c];
      res.prev = med_before[c];
      res.cmd = (c == 0) ? CMD_CH0 : CMD_CH1;
    end
    return res;
  endfunction

  // Offers one word, waits for it to be taken, and records what it should produce.
  // Called and returns at a falling edge.
  task automatic send_word(input logic [2:0] ch, input logic [15:0] smp,
                           input bit typed, input pcmf_result_t typed_res);
    pcmf_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ch;
    in_tdata  <= smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = filter_predict(ch, smp);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Sample values lean toward extremes and a narrow band so ties are common.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(4))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          2: return SAMPLE_NEG1;
          3: return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      default: return 16'($urandom_range(16)) - 16'd8;
    endcase
  endfunction

  // Receiver ready, with an occasional long hold-off to back the block up.
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compares every result word with the oldest expectation.
  always @(posedge clk) begin
    pcmf_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: tdata=%h tuser=%b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.acc) begin
          $error("accepted: expected %b, got %b", want.acc, out_tuser[0]);
          fail_count++;
        end
        if (out_tdata[15:0] !== want.median) begin
          $error("median: expected %h, got %h", want.median, out_tdata[15:0]);
          fail_count++;
        end
        if (out_tdata[31:16] !== want.prev) begin
          $error("previous_median: expected %h, got %h", want.prev, out_tdata[31:16]);
          fail_count++;
        end
        if (out_tdata[47:32] !== want.cmd) begin
          $error("command_word: expected %h, got %h", want.cmd, out_tdata[47:32]);
          fail_count++;
        end
      end
    end
  end

  // Reset, directed table, random phases, then drain and report.
  initial begin
    int           phase_send [4] = '{0, 67, 0, 10};
    int           phase_recv [4] = '{0, 0, 67, 10};
    pcmf_result_t typed_res;
    logic [2:0]   cur_ch;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    hold_served = 0;
    cur_ch = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      wr_slot[c] = 0;
      med_now[c] = '0;
      med_before[c] = '0;
      for (int k = 0; k < WINDOW_SIZE; k++) win_mem[c][k] = '0;
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part.
    foreach (directed_rows[r]) begin
      typed_res.acc = directed_rows[r].exp_acc;
      typed_res.median = directed_rows[r].exp_med;
      typed_res.prev = directed_rows[r].exp_prev;
      typed_res.cmd = directed_rows[r].exp_cmd;
      send_word(directed_rows[r].ch, directed_rows[r].smp, directed_rows[r].typed, typed_res);
    end

    // Random phases; channels come in runs so windows fill and wrap.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      if (ph == 0) hold_requests++;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(99) >= 70) begin
          if ($urandom_range(99) < 15) cur_ch = 3'($urandom_range(7, 2));
          else cur_ch = 3'($urandom_range(1));
        end
        send_word(cur_ch, pick_sample(), 1'b0, typed_res);
      end
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pcmf_pkg.sv
rtl/pcmf_front.sv
rtl/pcmf_queue.sv
rtl/pcmf_back.sv
rtl/per_channel_median_filter_unit.sv
dv/testbench.sv
